### rtl/core/circle_elastic_collision_unit_macros.svh
// ---------------------------------------------------------------------------
// circle elastic collision unit - assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef CIRCLE_ELASTIC_COLLISION_UNIT_MACROS_SVH
`define CIRCLE_ELASTIC_COLLISION_UNIT_MACROS_SVH

// same-cycle implication
`define CEC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/cec_pkg.sv
// ---------------------------------------------------------------------------
// cec_pkg
// Types, widths and codes shared by the circle elastic collision unit.
// ---------------------------------------------------------------------------
package cec_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int SW   = 2 * VALUE_WIDTH + 1;   // squared distance
    localparam int RB   = (SW + 1) / 2;          // integer square root
    localparam int DOTW = 2 * VALUE_WIDTH + 2;   // 2 * |dv . d|
    localparam int TVW  = 3 * VALUE_WIDTH + 2;
    localparam int NVW  = 4 * VALUE_WIDTH + 2;
    localparam int DVW  = 3 * VALUE_WIDTH + 2;
    localparam int TPW  = 2 * VALUE_WIDTH + 1;
    localparam int NPW  = 3 * VALUE_WIDTH + 1;
    localparam int DPW  = 2 * VALUE_WIDTH + 2;
    localparam int QB   = VALUE_WIDTH + 1;       // quotient bits before clamp
    localparam int EXW  = VALUE_WIDTH + 3;

    localparam logic signed [VALUE_WIDTH-1:0] SMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] SMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_HIT  = 2'd1;
    localparam logic [1:0] ST_COIN = 2'd2;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] a_pos_x;
        logic signed [VALUE_WIDTH-1:0] a_pos_y;
        logic signed [VALUE_WIDTH-1:0] b_pos_x;
        logic signed [VALUE_WIDTH-1:0] b_pos_y;
        logic signed [VALUE_WIDTH-1:0] a_vel_x;
        logic signed [VALUE_WIDTH-1:0] a_vel_y;
        logic signed [VALUE_WIDTH-1:0] b_vel_x;
        logic signed [VALUE_WIDTH-1:0] b_vel_y;
        logic [VALUE_WIDTH-1:0]        a_mass;
        logic [VALUE_WIDTH-1:0]        b_mass;
        logic [VALUE_WIDTH-1:0]        a_radius;
        logic [VALUE_WIDTH-1:0]        b_radius;
    } in_t;

    typedef struct packed {
        logic [1:0]                    status;
        logic signed [VALUE_WIDTH-1:0] new_a_pos_x;
        logic signed [VALUE_WIDTH-1:0] new_a_pos_y;
        logic signed [VALUE_WIDTH-1:0] new_b_pos_x;
        logic signed [VALUE_WIDTH-1:0] new_b_pos_y;
        logic signed [VALUE_WIDTH-1:0] new_a_vel_x;
        logic signed [VALUE_WIDTH-1:0] new_a_vel_y;
        logic signed [VALUE_WIDTH-1:0] new_b_vel_x;
        logic signed [VALUE_WIDTH-1:0] new_b_vel_y;
    } out_t;

    // front-end results handed to the root and the dividers
    typedef struct packed {
        in_t                    d;
        logic [VALUE_WIDTH:0]   r;
        logic [VALUE_WIDTH-1:0] ma;
        logic [VALUE_WIDTH-1:0] mb;
        logic [VALUE_WIDTH:0]   m;
        logic [SW-1:0]          s;
        logic                   hit;
        logic                   coin;
        logic                   dot_neg;
        logic [DOTW-1:0]        dot_mag;
        logic [VALUE_WIDTH-1:0] dx_mag;
        logic [VALUE_WIDTH-1:0] dy_mag;
        logic                   dx_neg;
        logic                   dy_neg;
    } fr_t;

endpackage

### rtl/core/cec_isqrt.sv
// ---------------------------------------------------------------------------
// cec_isqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ---------------------------------------------------------------------------
module cec_isqrt #(
    parameter int SQW = 65,
    parameter int SBW = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    i_valid,
    input  logic [SQW-1:0]          i_s,
    input  logic [SBW-1:0]          i_sb,
    output logic                    o_valid,
    output logic [(SQW+1)/2-1:0]    o_root,
    output logic [SBW-1:0]          o_sb
);
    localparam int NB = (SQW + 1) / 2;
    localparam int XW = 2 * NB;

    logic [XW-1:0]  num_reg [0:NB-1];
    logic [XW-1:0]  res_reg [0:NB-1];
    logic [SBW-1:0] sb_reg  [0:NB-1];
    logic           v_reg   [0:NB-1];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        localparam logic [XW-1:0] BITV = XW'(1) << (2 * (NB - 1 - k));
        logic [XW-1:0]  n_in, r_in, tr;
        logic [SBW-1:0] sb_in;
        logic           v_in, ge;

        if (k == 0) begin : g_first
            assign n_in  = XW'(i_s);
            assign r_in  = '0;
            assign sb_in = i_sb;
            assign v_in  = i_valid;
        end else begin : g_next
            assign n_in  = num_reg[k-1];
            assign r_in  = res_reg[k-1];
            assign sb_in = sb_reg[k-1];
            assign v_in  = v_reg[k-1];
        end

        assign tr = r_in + BITV;
        assign ge = (n_in >= tr);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k] <= ge ? n_in - tr : n_in;
                res_reg[k] <= ge ? (r_in >> 1) + BITV : (r_in >> 1);
                sb_reg[k]  <= sb_in;
            end
        end
    end

    assign o_valid = v_reg[NB-1];
    assign o_root  = res_reg[NB-1][NB-1:0];
    assign o_sb    = sb_reg[NB-1];

endmodule

### rtl/core/cec_rdiv.sv
// ---------------------------------------------------------------------------
// cec_rdiv
// Pipelined restoring divider, round to nearest with ties away from zero,
// quotient clamped to QBITS bits with an overflow flag. Also holds the
// pipelined wide by narrow multiplier that feeds it.
// ---------------------------------------------------------------------------
module cec_rdiv #(
    parameter int NW    = 130,
    parameter int DW    = 98,
    parameter int QBITS = 33,
    parameter int SBW   = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              i_valid,
    input  logic [NW-1:0]     i_num,
    input  logic [DW-1:0]     i_den,
    input  logic [SBW-1:0]    i_sb,
    output logic              o_valid,
    output logic [QBITS-1:0]  o_q,
    output logic              o_ovf,
    output logic [SBW-1:0]    o_sb
);
    localparam int AW = NW + 2;
    localparam int CW = (AW > DW + 1 + QBITS) ? AW : DW + 1 + QBITS;
    localparam int NS = QBITS + 2;

    logic [CW-1:0]    rem_reg [0:NS-1];
    logic [DW:0]      d2_reg  [0:NS-1];
    logic [QBITS-1:0] q_reg   [0:NS-1];
    logic             ovf_reg [0:NS-1];
    logic [SBW-1:0]   sb_reg  [0:NS-1];
    logic             v_reg   [0:NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= (k == 0) ? i_valid : v_reg[(k == 0) ? 0 : k-1];
            end
        end

        if (k == 0) begin : g_add
            // 2|n| + d over 2d gives the rounded quotient by flooring
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= CW'({i_num, 1'b0}) + CW'(i_den);
                    d2_reg[k]  <= {i_den, 1'b0};
                    q_reg[k]   <= '0;
                    ovf_reg[k] <= 1'b0;
                    sb_reg[k]  <= i_sb;
                end
            end
        end else if (k == 1) begin : g_range
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_reg[k-1];
                    d2_reg[k]  <= d2_reg[k-1];
                    q_reg[k]   <= q_reg[k-1];
                    ovf_reg[k] <= (rem_reg[k-1] >= (CW'(d2_reg[k-1]) << QBITS));
                    sb_reg[k]  <= sb_reg[k-1];
                end
            end
        end else begin : g_bit
            localparam int B = QBITS + 1 - k;
            logic [CW-1:0] trial;
            logic          ge;
            assign trial = CW'(d2_reg[k-1]) << B;
            assign ge    = (rem_reg[k-1] >= trial);
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? rem_reg[k-1] - trial : rem_reg[k-1];
                    d2_reg[k]  <= d2_reg[k-1];
                    q_reg[k]   <= q_reg[k-1] | (QBITS'(ge) << B);
                    ovf_reg[k] <= ovf_reg[k-1];
                    sb_reg[k]  <= sb_reg[k-1];
                end
            end
        end
    end

    assign o_valid = v_reg[NS-1];
    assign o_q     = q_reg[NS-1];
    assign o_ovf   = ovf_reg[NS-1];
    assign o_sb    = sb_reg[NS-1];

endmodule

// ---------------------------------------------------------------------------
// cec_pmul
// Pipelined wide by narrow unsigned multiplier, one 32-bit limb of the wide
// operand per stage, with valid and sideband.
// ---------------------------------------------------------------------------
module cec_pmul #(
    parameter int AW  = 66,
    parameter int BW  = 33,
    parameter int NL  = 3,
    parameter int SBW = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              i_valid,
    input  logic [AW-1:0]     i_a,
    input  logic [BW-1:0]     i_b,
    input  logic [SBW-1:0]    i_sb,
    output logic              o_valid,
    output logic [AW+BW-1:0]  o_p,
    output logic [SBW-1:0]    o_sb
);
    localparam int LW = 32;
    localparam int PW = AW + BW;
    localparam int XW = LW * NL;

    logic [XW-1:0]  a_reg   [0:NL-1];
    logic [BW-1:0]  b_reg   [0:NL-1];
    logic [PW-1:0]  acc_reg [0:NL-1];
    logic [SBW-1:0] sb_reg  [0:NL-1];
    logic           v_reg   [0:NL-1];

    for (genvar k = 0; k < NL; k++) begin : g_stage
        logic [XW-1:0]    a_in;
        logic [BW-1:0]    b_in;
        logic [PW-1:0]    acc_in;
        logic [SBW-1:0]   sb_in;
        logic             v_in;
        logic [LW+BW-1:0] pp;

        if (k == 0) begin : g_first
            assign a_in   = XW'(i_a);
            assign b_in   = i_b;
            assign acc_in = '0;
            assign sb_in  = i_sb;
            assign v_in   = i_valid;
        end else begin : g_next
            assign a_in   = a_reg[k-1];
            assign b_in   = b_reg[k-1];
            assign acc_in = acc_reg[k-1];
            assign sb_in  = sb_reg[k-1];
            assign v_in   = v_reg[k-1];
        end

        // one limb partial product per stage
        assign pp = (LW+BW)'(a_in[LW*k +: LW]) * (LW+BW)'(b_in);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[k]   <= a_in;
                b_reg[k]   <= b_in;
                acc_reg[k] <= acc_in + (PW'(pp) << (LW * k));
                sb_reg[k]  <= sb_in;
            end
        end
    end

    assign o_valid = v_reg[NL-1];
    assign o_p     = acc_reg[NL-1];
    assign o_sb    = sb_reg[NL-1];

endmodule

### rtl/core/cec_front.sv
// ---------------------------------------------------------------------------
// cec_front
// Three stages: differences, products, then squared distance, contact test
// and the impulse dot product.
// ---------------------------------------------------------------------------
module cec_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          i_valid,
    input  cec_pkg::in_t  i_data,
    output logic          o_valid,
    output cec_pkg::fr_t  o_data
);
    import cec_pkg::*;

    localparam int VW = VALUE_WIDTH;

    typedef struct packed {
        in_t                 d;
        logic signed [VW:0]  dx;
        logic signed [VW:0]  dy;
        logic [VW:0]         r;
        logic [VW-1:0]       ma;
        logic [VW-1:0]       mb;
        logic [VW:0]         m;
        logic signed [VW:0]  dvx;
        logic signed [VW:0]  dvy;
    } st1_t;

    typedef struct packed {
        in_t                     d;
        logic [VW:0]             r;
        logic [VW-1:0]           ma;
        logic [VW-1:0]           mb;
        logic [VW:0]             m;
        logic signed [2*VW+1:0]  sqx;
        logic signed [2*VW+1:0]  sqy;
        logic [2*VW+1:0]         r2;
        logic signed [2*VW+1:0]  px;
        logic signed [2*VW+1:0]  py;
        logic signed [VW:0]      dx;
        logic signed [VW:0]      dy;
    } st2_t;

    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    fr_t  st3_reg, st3_next;
    logic v1_reg, v2_reg, v3_reg;

    always_comb begin
        logic [VW:0] msum;
        st1_next.d   = i_data;
        st1_next.dx  = (VW+1)'(i_data.b_pos_x) - (VW+1)'(i_data.a_pos_x);
        st1_next.dy  = (VW+1)'(i_data.b_pos_y) - (VW+1)'(i_data.a_pos_y);
        st1_next.r   = (VW+1)'(i_data.a_radius) + (VW+1)'(i_data.b_radius);
        st1_next.dvx = (VW+1)'(i_data.a_vel_x) - (VW+1)'(i_data.b_vel_x);
        st1_next.dvy = (VW+1)'(i_data.a_vel_y) - (VW+1)'(i_data.b_vel_y);
        msum = (VW+1)'(i_data.a_mass) + (VW+1)'(i_data.b_mass);
        // two massless bodies act as equal masses
        if (msum == '0) begin
            st1_next.ma = VW'(1);
            st1_next.mb = VW'(1);
            st1_next.m  = (VW+1)'(2);
        end else begin
            st1_next.ma = i_data.a_mass;
            st1_next.mb = i_data.b_mass;
            st1_next.m  = msum;
        end
    end

    always_comb begin
        st2_next.d   = st1_reg.d;
        st2_next.r   = st1_reg.r;
        st2_next.ma  = st1_reg.ma;
        st2_next.mb  = st1_reg.mb;
        st2_next.m   = st1_reg.m;
        st2_next.sqx = st1_reg.dx * st1_reg.dx;
        st2_next.sqy = st1_reg.dy * st1_reg.dy;
        st2_next.r2  = (2*VW+2)'(st1_reg.r) * (2*VW+2)'(st1_reg.r);
        st2_next.px  = (2*VW+2)'(st1_reg.dvx) * (2*VW+2)'(st1_reg.dx);
        st2_next.py  = (2*VW+2)'(st1_reg.dvy) * (2*VW+2)'(st1_reg.dy);
        st2_next.dx  = st1_reg.dx;
        st2_next.dy  = st1_reg.dy;
    end

    always_comb begin
        logic signed [DOTW-1:0] dsum;
        logic [DOTW-1:0]        dabs;
        logic [SW-1:0]          s;
        s    = SW'(st2_reg.sqx[2*VW-1:0]) + SW'(st2_reg.sqy[2*VW-1:0]);
        dsum = st2_reg.px + st2_reg.py;
        dabs = dsum[DOTW-1] ? DOTW'(-dsum) : DOTW'(dsum);
        st3_next.d       = st2_reg.d;
        st3_next.r       = st2_reg.r;
        st3_next.ma      = st2_reg.ma;
        st3_next.mb      = st2_reg.mb;
        st3_next.m       = st2_reg.m;
        st3_next.s       = s;
        st3_next.hit     = (st2_reg.r2 > (2*VW+2)'(s));
        st3_next.coin    = (s == '0);
        st3_next.dot_neg = dsum[DOTW-1];
        st3_next.dot_mag = {dabs[DOTW-2:0], 1'b0};
        st3_next.dx_neg  = st2_reg.dx[VW];
        st3_next.dy_neg  = st2_reg.dy[VW];
        st3_next.dx_mag  = st2_reg.dx[VW] ? VW'(-st2_reg.dx) : VW'(st2_reg.dx);
        st3_next.dy_mag  = st2_reg.dy[VW] ? VW'(-st2_reg.dy) : VW'(st2_reg.dy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= i_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
        end
    end

    assign o_valid = v3_reg;
    assign o_data  = st3_reg;

endmodule

### rtl/core/circle_elastic_collision_unit.sv
// ---------------------------------------------------------------------------
// circle_elastic_collision_unit
// Elastic collision and separation of two circles, fully pipelined.
// ---------------------------------------------------------------------------
// Takes one circle pair per cycle and returns one result beat per pair, in
// order, at 32-bit values. A pair passes 3 front stages, one square root
// stage per root bit (33), 3 limb stages for the denominator and impulse
// products, 4 limb stages for the mass products, one divider stage per
// quotient bit plus two (35), and the output register. Throughput is one
// beat per cycle. Back pressure on m_ready freezes the whole pipeline, so
// s_ready follows it.
// ---------------------------------------------------------------------------
`include "circle_elastic_collision_unit_macros.svh"

module circle_elastic_collision_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cec_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output cec_pkg::out_t  m_data
);
    import cec_pkg::*;

    localparam int VW = VALUE_WIDTH;

    typedef struct packed {
        in_t        d;
        logic [1:0] status;
        logic [3:0] neg;      // vel x, vel y, pos x, pos y
    } sb_t;

    typedef struct packed {
        sb_t                       sb;
        logic [VW-1:0]             ma;
        logic [VW-1:0]             mb;
        logic [DPW-1:0]            den_p;
        logic [1:0][TPW-1:0]       tp;     // 1 y, 0 x
    } pa_t;

    typedef struct packed {
        sb_t                       sb;
        logic [DVW-1:0]            den_v;
        logic [DPW-1:0]            den_p;
    } pb_t;

    logic en;
    logic fr_valid, sq_valid, dv_valid;
    fr_t  fr_data, sq_sb;
    logic [RB-1:0] sq_root;
    pa_t  pa_in, pa_out;
    pb_t  pb_in, pb_out;
    logic pa_valid, pb_valid;
    logic [DVW-1:0] den_v;
    logic [TVW-1:0] tv   [0:1];    // 0 x, 1 y
    logic [NVW-1:0] vnum [0:3];
    logic [NPW-1:0] pnum [0:3];
    logic [QB-1:0] vq [0:3];
    logic [QB-1:0] pq [0:3];
    logic          vovf [0:3];
    logic          povf [0:3];
    sb_t  dv_sb;
    out_t m_data_reg, m_data_next;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    cec_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_valid (s_valid),
        .i_data  (s_data),
        .o_valid (fr_valid),
        .o_data  (fr_data)
    );

    cec_isqrt #(.SQW(SW), .SBW($bits(fr_t))) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_valid (fr_valid),
        .i_s     (fr_data.s),
        .i_sb    (fr_data),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_sb    (sq_sb)
    );

    always_comb begin
        logic [VW:0] ov;
        ov = sq_sb.r - (VW+1)'(sq_root);
        pa_in.sb.d      = sq_sb.d;
        pa_in.sb.status = !sq_sb.hit ? ST_NONE : (sq_sb.coin ? ST_COIN : ST_HIT);
        pa_in.sb.neg    = {sq_sb.dot_neg ^ sq_sb.dx_neg, sq_sb.dot_neg ^ sq_sb.dy_neg,
                           sq_sb.dx_neg, sq_sb.dy_neg};
        pa_in.ma    = sq_sb.ma;
        pa_in.mb    = sq_sb.mb;
        pa_in.den_p = DPW'(sq_root) * DPW'(sq_sb.m);
        pa_in.tp[0] = TPW'(ov) * TPW'(sq_sb.dx_mag);
        pa_in.tp[1] = TPW'(ov) * TPW'(sq_sb.dy_mag);
    end

    // m * s and 2|dot| * |d|, one limb per stage
    cec_pmul #(.AW(SW), .BW(VW+1), .NL(3), .SBW($bits(pa_t))) u_denv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_valid (sq_valid),
        .i_a     (sq_sb.s),
        .i_b     (sq_sb.m),
        .i_sb    (pa_in),
        .o_valid (pa_valid),
        .o_p     (den_v),
        .o_sb    (pa_out)
    );

    for (genvar k = 0; k < 2; k++) begin : g_tv
        cec_pmul #(.AW(DOTW), .BW(VW), .NL(3), .SBW(1)) u_tv (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .i_valid (sq_valid),
            .i_a     (sq_sb.dot_mag),
            .i_b     ((k == 0) ? sq_sb.dx_mag : sq_sb.dy_mag),
            .i_sb    (1'b0),
            .o_valid (),
            .o_p     (tv[k]),
            .o_sb    ()
        );
    end

    always_comb begin
        pb_in.sb    = pa_out.sb;
        pb_in.den_v = den_v;
        pb_in.den_p = pa_out.den_p;
    end

    // lane k: 0 a x, 1 a y, 2 b x, 3 b y; body a scales by mb, body b by ma
    for (genvar k = 0; k < 4; k++) begin : g_mul
        logic [VW-1:0] mass;
        assign mass = (k < 2) ? pa_out.mb : pa_out.ma;
        if (k == 0) begin : g_lead
            cec_pmul #(.AW(TVW), .BW(VW), .NL(4), .SBW($bits(pb_t))) u_vmul (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .i_valid (pa_valid),
                .i_a     (tv[k % 2]),
                .i_b     (mass),
                .i_sb    (pb_in),
                .o_valid (pb_valid),
                .o_p     (vnum[k]),
                .o_sb    (pb_out)
            );
        end else begin : g_rest
            cec_pmul #(.AW(TVW), .BW(VW), .NL(4), .SBW(1)) u_vmul (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .i_valid (pa_valid),
                .i_a     (tv[k % 2]),
                .i_b     (mass),
                .i_sb    (1'b0),
                .o_valid (),
                .o_p     (vnum[k]),
                .o_sb    ()
            );
        end
        cec_pmul #(.AW(TPW), .BW(VW), .NL(4), .SBW(1)) u_pmul (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .i_valid (pa_valid),
            .i_a     (pa_out.tp[k % 2]),
            .i_b     (mass),
            .i_sb    (1'b0),
            .o_valid (),
            .o_p     (pnum[k]),
            .o_sb    ()
        );
    end

    // divider k: 0 a x, 1 a y, 2 b x, 3 b y
    for (genvar k = 0; k < 4; k++) begin : g_div
        if (k == 0) begin : g_lead
            cec_rdiv #(.NW(NVW), .DW(DVW), .QBITS(QB), .SBW($bits(sb_t))) u_vdiv (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .i_valid (pb_valid),
                .i_num   (vnum[k]),
                .i_den   (pb_out.den_v),
                .i_sb    (pb_out.sb),
                .o_valid (dv_valid),
                .o_q     (vq[k]),
                .o_ovf   (vovf[k]),
                .o_sb    (dv_sb)
            );
        end else begin : g_rest
            cec_rdiv #(.NW(NVW), .DW(DVW), .QBITS(QB), .SBW(1)) u_vdiv (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .i_valid (pb_valid),
                .i_num   (vnum[k]),
                .i_den   (pb_out.den_v),
                .i_sb    (1'b0),
                .o_valid (),
                .o_q     (vq[k]),
                .o_ovf   (vovf[k]),
                .o_sb    ()
            );
        end
        cec_rdiv #(.NW(NPW), .DW(DPW), .QBITS(QB), .SBW(1)) u_pdiv (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .i_valid (pb_valid),
            .i_num   (pnum[k]),
            .i_den   (pb_out.den_p),
            .i_sb    (1'b0),
            .o_valid (),
            .o_q     (pq[k]),
            .o_ovf   (povf[k]),
            .o_sb    ()
        );
    end

    function automatic logic signed [VW-1:0] apply_delta(
        input logic signed [VW-1:0] p,
        input logic                 neg,
        input logic [QB-1:0]        q,
        input logic                 ovf,
        input logic                 sub
    );
        logic signed [EXW-1:0] qs;
        logic signed [EXW-1:0] sum;
        logic                  down;
        down = neg ^ sub;
        qs   = signed'(EXW'(q));
        if (down) begin
            qs = -qs;
        end
        sum = EXW'(p) + qs;
        if (ovf) begin
            return down ? SMIN : SMAX;
        end else if (sum > EXW'(SMAX)) begin
            return SMAX;
        end else if (sum < EXW'(SMIN)) begin
            return SMIN;
        end else begin
            return sum[VW-1:0];
        end
    endfunction

    always_comb begin
        m_data_next.status = dv_sb.status;
        if (dv_sb.status == ST_HIT) begin
            m_data_next.new_a_vel_x = apply_delta(dv_sb.d.a_vel_x, dv_sb.neg[3], vq[0],
                                                  vovf[0], 1'b1);
            m_data_next.new_a_vel_y = apply_delta(dv_sb.d.a_vel_y, dv_sb.neg[2], vq[1],
                                                  vovf[1], 1'b1);
            m_data_next.new_b_vel_x = apply_delta(dv_sb.d.b_vel_x, dv_sb.neg[3], vq[2],
                                                  vovf[2], 1'b0);
            m_data_next.new_b_vel_y = apply_delta(dv_sb.d.b_vel_y, dv_sb.neg[2], vq[3],
                                                  vovf[3], 1'b0);
            m_data_next.new_a_pos_x = apply_delta(dv_sb.d.a_pos_x, dv_sb.neg[1], pq[0],
                                                  povf[0], 1'b1);
            m_data_next.new_a_pos_y = apply_delta(dv_sb.d.a_pos_y, dv_sb.neg[0], pq[1],
                                                  povf[1], 1'b1);
            m_data_next.new_b_pos_x = apply_delta(dv_sb.d.b_pos_x, dv_sb.neg[1], pq[2],
                                                  povf[2], 1'b0);
            m_data_next.new_b_pos_y = apply_delta(dv_sb.d.b_pos_y, dv_sb.neg[0], pq[3],
                                                  povf[3], 1'b0);
        end else begin
            m_data_next.new_a_vel_x = dv_sb.d.a_vel_x;
            m_data_next.new_a_vel_y = dv_sb.d.a_vel_y;
            m_data_next.new_b_vel_x = dv_sb.d.b_vel_x;
            m_data_next.new_b_vel_y = dv_sb.d.b_vel_y;
            m_data_next.new_a_pos_x = dv_sb.d.a_pos_x;
            m_data_next.new_a_pos_y = dv_sb.d.a_pos_y;
            m_data_next.new_b_pos_x = dv_sb.d.b_pos_x;
            m_data_next.new_b_pos_y = dv_sb.d.b_pos_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `CEC_ASSERT_IMP(a_status_legal, m_valid, m_data.status == ST_NONE || m_data.status == ST_HIT || m_data.status == ST_COIN, "illegal status code")
    `CEC_ASSERT_NEXT(a_stall_freezes, !en, $stable(fr_valid) && $stable(dv_valid), "pipeline moved during stall")
    `CEC_ASSERT_NEXT(a_result_kept, en && dv_valid, m_valid, "finished beat dropped")

endmodule
